/* design/min_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// Minimum priority queue assertion macros
// Shared check macros for the queue; they reduce to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define MPQ_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Checks that a consequence holds in the cycle after its cause.
`define MPQ_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPQ_CHECK(label, cond, msg)
`define MPQ_CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// Minimum priority queue package
// Command and result types, status codes and cell control shared by the queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned PORT_KEY_W = 32;
  localparam int unsigned OCC_W      = 7;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } mpq_status_t;

  typedef struct packed {
    logic                          mode;
    logic signed [PORT_KEY_W-1:0] key_in;
  } mpq_cmd_t;

  typedef struct packed {
    logic signed [PORT_KEY_W-1:0] removed_key;
    logic signed [PORT_KEY_W-1:0] current_min;
    logic [OCC_W-1:0]             occupancy;
    logic                         queue_empty;
    mpq_status_t                  status;
  } mpq_result_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic ext;
  } mpq_op_t;

endpackage

/* design/mpq_cell.sv */
// ----------------------------------------------------------------------------
// Minimum priority queue cell
// One slot of the sorted row; takes the new key, keeps its own or shifts.
// ----------------------------------------------------------------------------
module mpq_cell #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mpq_pkg::mpq_op_t            op,
  input  logic signed [KEY_WIDTH-1:0] new_key,
  input  logic                        left_valid,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic                        left_keep,
  input  logic                        right_valid,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  output logic                        valid,
  output logic signed [KEY_WIDTH-1:0] key,
  output logic                        keep
);
  import mpq_pkg::*;

  logic                        valid_next;
  logic signed [KEY_WIDTH-1:0] key_next;

  // A cell keeps its key on insert when it holds one no larger than the new key.
  assign keep = valid && (key <= new_key);

  always_comb begin
    valid_next = valid;
    key_next   = key;
    if (op.ins) begin
      if (!keep) begin
        if (left_keep) begin
          valid_next = 1'b1;
          key_next   = new_key;
        end else begin
          valid_next = left_valid;
          key_next   = left_key;
        end
      end
    end else if (op.ext) begin
      valid_next = right_valid;
      key_next   = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

/* design/min_priority_queue.sv */
// ----------------------------------------------------------------------------
// Minimum priority queue
// Bounded queue of signed keys kept sorted in a row of cells, smallest first.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                 Transfer happens when
//   --------  --------------------  ------------------------------------
//   command   start, busy, cmd      start is high and busy is low
//   result    done, result          done is high (one cycle, no stall)
//
// The cells update at the edge that takes the command, in the single
// compare-and-shift step of the cell row. The result, with the new head
// of the row read out, is shown in the following cycle, while busy is high.
// Reset empties the queue at once by clearing every cell's valid bit.
// The receiver cannot stall, so the next command may follow straight after.
//
`include "min_priority_queue_defines.svh"

module min_priority_queue #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mpq_pkg::mpq_cmd_t    cmd,
  output logic                 done,
  output mpq_pkg::mpq_result_t result
);
  import mpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Cell row: index 0 holds the smallest key, valid cells form a prefix.
  logic                        cell_valid [CAPACITY];
  logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];
  logic                        cell_keep  [CAPACITY];
  logic [CAPACITY-1:0]         valid_vec;

  logic                        accept;
  logic                        full;
  logic                        empty;
  mpq_op_t                     op;
  logic signed [KEY_WIDTH-1:0] new_key;
  logic [KEY_WIDTH+PORT_KEY_W-1:0] key_in_ext;

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic signed [KEY_WIDTH-1:0] removed;
  mpq_status_t                 status;
  mpq_status_t                 status_next;

  logic [KEY_WIDTH+PORT_KEY_W-1:0] removed_ext;
  logic [KEY_WIDTH+PORT_KEY_W-1:0] head_ext;
  logic [CNT_W+OCC_W-1:0]          count_ext;

  // The command is taken only while no result is on show.
  assign busy   = done;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);

  // The incoming key is sign-extended or cut to the width of the cells.
  assign key_in_ext = {{KEY_WIDTH{cmd.key_in[PORT_KEY_W-1]}}, cmd.key_in};
  assign new_key    = key_in_ext[KEY_WIDTH-1:0];

  // A full insert or an empty extract leaves the row untouched.
  assign op.ins = accept && (cmd.mode == MODE_INSERT) && !full;
  assign op.ext = accept && (cmd.mode == MODE_EXTRACT) && !empty;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                        l_valid;
      logic signed [KEY_WIDTH-1:0] l_key;
      logic                        l_keep;
      logic                        r_valid;
      logic signed [KEY_WIDTH-1:0] r_key;

      if (i == 0) begin : g_head
        // The head has nothing on its left: it always takes the new key
        // when it does not keep its own.
        assign l_valid = 1'b0;
        assign l_key   = '0;
        assign l_keep  = 1'b1;
      end else begin : g_body
        assign l_valid = cell_valid[i-1];
        assign l_key   = cell_key[i-1];
        assign l_keep  = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_key   = '0;
      end else begin : g_inner
        assign r_valid = cell_valid[i+1];
        assign r_key   = cell_key[i+1];
      end

      mpq_cell #(
        .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .op         (op),
        .new_key    (new_key),
        .left_valid (l_valid),
        .left_key   (l_key),
        .left_keep  (l_keep),
        .right_valid(r_valid),
        .right_key  (r_key),
        .valid      (cell_valid[i]),
        .key        (cell_key[i]),
        .keep       (cell_keep[i])
      );

      assign valid_vec[i] = cell_valid[i];
    end
  endgenerate

  // Occupancy and status of the command being taken.
  always_comb begin
    count_next  = count;
    status_next = STATUS_OK;
    if (accept) begin
      if (cmd.mode == MODE_INSERT) begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result payload is captured at the transfer and needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= status_next;
      removed <= op.ext ? cell_key[0] : '0;
    end
  end

  // The minimum after the command is simply the head of the row.
  assign removed_ext = {{PORT_KEY_W{removed[KEY_WIDTH-1]}}, removed};
  assign head_ext    = {{PORT_KEY_W{cell_key[0][KEY_WIDTH-1]}}, cell_key[0]};
  assign count_ext   = {{OCC_W{1'b0}}, count};

  always_comb begin
    result.removed_key = removed_ext[PORT_KEY_W-1:0];
    result.current_min = cell_valid[0] ? head_ext[PORT_KEY_W-1:0] : '0;
    result.occupancy   = count_ext[OCC_W-1:0];
    result.queue_empty = empty;
    result.status      = status;
  end

  // The count always equals the number of occupied cells.
  `MPQ_CHECK(a_count_matches, $countones(valid_vec) == count, "count and cells disagree")
  // Occupied cells form an unbroken run from the head.
  `MPQ_CHECK(a_valid_prefix, (valid_vec & (valid_vec + 1'b1)) == '0, "gap in cell row")
  // The head never holds a larger key than its neighbour.
  `MPQ_CHECK(a_head_smallest, !cell_valid[1] || (cell_key[0] <= cell_key[1]), "head not min")
  // Every transfer of a command yields a result in the next cycle.
  `MPQ_CHECK_NEXT(a_result_follows, accept, done && busy, "missing result strobe")

endmodule
